// File: hw/rtl/lmwc_pkg.sv
`timescale 1ns / 1ps
package lmwc_pkg;

  localparam int unsigned LagDefault = 64;
  localparam int unsigned QueueDepth = 2;

  localparam logic [63:0] MwcMult    = 64'h6b2b_8acc_beb4_2f68;
  localparam logic [63:0] CarryStart = 64'd1234567890;
  localparam logic [63:0] ScrOr      = 64'h0000_0000_4000_0005;
  localparam logic [63:0] ScrMult    = 64'd6906969069;
  localparam int unsigned RotA       = 17;
  localparam int unsigned RotB       = 53;
  localparam int unsigned HalfW      = 32;

  typedef enum logic {
    OP_GEN  = 1'b0,
    OP_SEED = 1'b1
  } op_e;

  typedef struct packed {
    logic        valid;
    op_e         op;
    logic [63:0] seed_lo;
    logic [63:0] seed_hi;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G_RD,
    ST_G_M0,
    ST_G_M1,
    ST_G_M2,
    ST_G_M3,
    ST_G_M4,
    ST_G_WR,
    ST_S_SQ0,
    ST_S_SQ1,
    ST_S_ADD,
    ST_S_U0,
    ST_S_U1,
    ST_S_MIX,
    ST_S_OUT
  } state_e;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

endpackage

// File: hw/rtl/lag64_multiply_with_carry_rng_top.sv
`timescale 1ns / 1ps
// Lag multiply-with-carry random word generator.
// Input channel (in_valid_i / in_stall_o): one word per operation.
//   operation_i = 0 asks for one random word; 1 seeds from seed_low_i and
//   seed_high_i, then warms up; a seed gives no output word.
// Output channel (out_valid_o / out_stall_i): random_word_o per generate.
// Words are accepted into a two-entry queue; the engine drains it in order.
// Generate: the engine steps through pop, read, five multiply-accumulate
//   and write states, and takes no new word until it is through (one
//   shared 32x32 multiplier, four partials); the write waits for a free output.
// Seed: each lag word runs two scrambler streams in turn on the same
//   multiplier (square, add, scramble multiply, mix, out); LAG*LAG warm-up
//   generate steps follow, with no output word.
// While the receiver stalls, the word holds; the engine finishes the next
//   word and waits, and the queue keeps taking input until it is full.
// Reset: all lag words, carry and index read as zero; output empty.
module lag64_multiply_with_carry_rng_top #(
  parameter int unsigned LAG = lmwc_pkg::LagDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] seed_low_i,
  input  logic [63:0] seed_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] random_word_o
);
  import lmwc_pkg::*;

  cmd_t cmd;
  logic pop;

  lmwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .seed_low_i  (seed_low_i),
    .seed_high_i (seed_high_i),
    .cmd_o       (cmd),
    .pop_i       (pop)
  );

  lmwc_back #(.LAG(LAG)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

endmodule

// File: hw/rtl/lmwc_front.sv
`timescale 1ns / 1ps
module lmwc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [63:0]         seed_low_i,
  input  logic [63:0]         seed_high_i,
  output lmwc_pkg::cmd_t      cmd_o,
  input  logic                pop_i
);
  import lmwc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_e         op_mem [QueueDepth];
  logic [63:0] lo_mem [QueueDepth];
  logic [63:0] hi_mem [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_stall_o = (cnt_q == CntW'(QueueDepth));
  assign push = in_valid_i && !in_stall_o;
  assign pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem[wr_q] <= operation_i ? OP_SEED : OP_GEN;
      lo_mem[wr_q] <= seed_low_i;
      hi_mem[wr_q] <= seed_high_i;
    end
  end

  assign cmd_o.valid   = (cnt_q != '0);
  assign cmd_o.op      = op_mem[rd_q];
  assign cmd_o.seed_lo = lo_mem[rd_q];
  assign cmd_o.seed_hi = hi_mem[rd_q];

endmodule

// File: hw/rtl/lmwc_back.sv
`timescale 1ns / 1ps
module lmwc_back #(
  parameter int unsigned LAG = lmwc_pkg::LagDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lmwc_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [63:0]    random_word_o
);
  import lmwc_pkg::*;

  localparam int unsigned IdxW  = $clog2(LAG);
  localparam int unsigned WarmW = $clog2(LAG * LAG + 1);

  logic [63:0] mem [LAG];
  logic [LAG-1:0] vld_q;

  state_e state_q, state_d;
  logic [IdxW-1:0]  ring_q, k_q, ring_nx;
  logic [WarmW-1:0] warm_cnt_q;
  logic             warm_q, sel_q;
  logic [63:0]      carry_q, s0_q, s1_q, w_q, tmp_q, uu_q, prod_q;
  logic [63:0]      rd_a_q, rd_b_q, x_w, y_w;
  logic             va_q, vb_q;
  logic [127:0]     acc_q, add_term;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      s_cur, u_w, sq_w, s_new, r_w, w_new;
  logic             out_free, out_valid_q, gen_done;
  logic [63:0]      out_q;

  assign ring_nx  = (ring_q == IdxW'(LAG - 1)) ? '0 : ring_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign gen_done = (state_q == ST_G_WR) && !warm_q && out_free;
  assign x_w      = va_q ? rd_a_q : '0;
  assign y_w      = vb_q ? rd_b_q : '0;
  assign s_cur    = sel_q ? s1_q : s0_q;
  assign u_w      = s_cur ^ (s_cur >> HalfW);
  assign sq_w     = tmp_q + {prod_q[30:0], 33'b0};
  assign s_new    = s_cur + (sq_w | ScrOr);
  assign r_w      = uu_q ^ rotl(uu_q, RotA) ^ rotl(uu_q, RotB);
  assign w_new    = sel_q ? (w_q + r_w) : r_w;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = (cmd_i.op == OP_SEED) ? ST_S_SQ0 : ST_G_RD;
        end
      end
      ST_G_RD:  state_d = ST_G_M0;
      ST_G_M0:  state_d = ST_G_M1;
      ST_G_M1:  state_d = ST_G_M2;
      ST_G_M2:  state_d = ST_G_M3;
      ST_G_M3:  state_d = ST_G_M4;
      ST_G_M4:  state_d = ST_G_WR;
      ST_G_WR: begin
        if (warm_q) begin
          state_d = (warm_cnt_q == WarmW'(1)) ? ST_IDLE : ST_G_RD;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_S_SQ0: state_d = ST_S_SQ1;
      ST_S_SQ1: state_d = ST_S_ADD;
      ST_S_ADD: state_d = ST_S_U0;
      ST_S_U0:  state_d = ST_S_U1;
      ST_S_U1:  state_d = ST_S_MIX;
      ST_S_MIX: state_d = ST_S_OUT;
      ST_S_OUT: begin
        state_d = (sel_q && k_q == IdxW'(LAG - 1)) ? ST_G_RD : ST_S_SQ0;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    add_term = '0;
    case (state_q)
      ST_IDLE:  pop_o = cmd_i.valid;
      ST_G_M0: begin
        mul_a = MwcMult[31:0];
        mul_b = x_w[31:0];
      end
      ST_G_M1: begin
        mul_a    = MwcMult[31:0];
        mul_b    = x_w[63:32];
        add_term = {64'b0, prod_q};
      end
      ST_G_M2: begin
        mul_a    = MwcMult[63:32];
        mul_b    = x_w[31:0];
        add_term = {32'b0, prod_q, 32'b0};
      end
      ST_G_M3: begin
        mul_a    = MwcMult[63:32];
        mul_b    = x_w[63:32];
        add_term = {32'b0, prod_q, 32'b0};
      end
      ST_G_M4:  add_term = {prod_q, 64'b0};
      ST_S_SQ0: begin
        mul_a = s_cur[31:0];
        mul_b = s_cur[31:0];
      end
      ST_S_SQ1: begin
        mul_a = s_cur[31:0];
        mul_b = s_cur[63:32];
      end
      ST_S_U0: begin
        mul_a = u_w[31:0];
        mul_b = ScrMult[31:0];
      end
      ST_S_U1: begin
        mul_a = u_w[63:32];
        mul_b = ScrMult[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      ring_q      <= '0;
      carry_q     <= '0;
      warm_q      <= 1'b0;
      warm_cnt_q  <= '0;
      sel_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gen_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_i.valid) begin
            warm_q <= 1'b0;
            sel_q  <= 1'b0;
            k_q    <= '0;
          end
        end
        ST_G_WR: begin
          if (warm_q || out_free) begin
            vld_q[ring_q] <= 1'b1;
            carry_q       <= acc_q[127:64];
            ring_q        <= ring_nx;
          end
          if (warm_q) begin
            warm_cnt_q <= warm_cnt_q - 1'b1;
          end
        end
        ST_S_ADD: begin
          if (!sel_q) begin
            sel_q <= 1'b0;
          end
        end
        ST_S_OUT: begin
          sel_q <= !sel_q;
          if (sel_q) begin
            vld_q[k_q] <= 1'b1;
            k_q        <= (k_q == IdxW'(LAG - 1)) ? '0 : k_q + 1'b1;
            if (k_q == IdxW'(LAG - 1)) begin
              ring_q     <= '0;
              carry_q    <= CarryStart;
              warm_q     <= 1'b1;
              warm_cnt_q <= WarmW'(LAG * LAG);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
    case (state_q)
      ST_IDLE: begin
        s0_q <= cmd_i.seed_lo;
        s1_q <= cmd_i.seed_hi;
      end
      ST_G_RD: begin
        rd_a_q <= mem[ring_q];
        rd_b_q <= mem[ring_nx];
        va_q   <= vld_q[ring_q];
        vb_q   <= vld_q[ring_nx];
      end
      ST_G_M0: acc_q <= {64'b0, y_w} + {64'b0, carry_q};
      ST_G_M1, ST_G_M2, ST_G_M3, ST_G_M4: acc_q <= acc_q + add_term;
      ST_G_WR: begin
        if (warm_q || out_free) begin
          mem[ring_q] <= acc_q[63:0];
        end
        if (!warm_q && out_free) begin
          out_q <= acc_q[63:0];
        end
      end
      ST_S_SQ1: tmp_q <= prod_q;
      ST_S_ADD: begin
        if (sel_q) begin
          s1_q <= s_new;
        end else begin
          s0_q <= s_new;
        end
      end
      ST_S_U1:  tmp_q <= prod_q;
      ST_S_MIX: begin
        uu_q <= tmp_q + {prod_q[31:0], 32'b0}
              + {32'(u_w[31:0] * ScrMult[63:32]), 32'b0};
      end
      ST_S_OUT: begin
        w_q <= w_new;
        if (sel_q) begin
          mem[k_q] <= w_new;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_q;

endmodule

// File: hw/rtl/lmwc_checker.sv
`timescale 1ns / 1ps
module lmwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] random_word_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(random_word_o))
    else $error("output word changed while stalled");

  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_stall_o) && !$isunknown(out_valid_o))
    else $error("handshake output unknown");

  a_word_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(random_word_o))
    else $error("output word unknown while valid");

endmodule

bind lag64_multiply_with_carry_rng_top lmwc_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .random_word_o (random_word_o)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lmwc_pkg::*;

  localparam int unsigned Lag = 64;
  localparam int RandWords = 950;
  localparam int MaxRandSeeds = 8;

  typedef struct {
    op_e         op;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          typed;
    logic [63:0] word;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = 1'b0;
  logic [63:0] seed_low_i = '0;
  logic [63:0] seed_high_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] random_word_o;

  logic [63:0] mwc_words [Lag];
  logic [63:0] mwc_carry;
  int unsigned mwc_idx;
  logic [63:0] pending_words [$];
  bit          typed_q [$];
  logic [63:0] typed_word_q [$];
  bit          cur_typed = 0;
  logic [63:0] cur_word = '0;
  row_t        dir_rows [$];
  int          errors = 0;
  int          accepted = 0;
  int          gen_count = 0;
  int          seed_count = 0;
  int          checked = 0;
  bit          hold_done = 0;

  lag64_multiply_with_carry_rng_top uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rol64(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] scramble_next(ref logic [63:0] s);
    logic [63:0] u;
    s = s + ((s * s) | ScrOr);
    u = s ^ (s >> HalfW);
    u = u * ScrMult;
    return u ^ rol64(u, RotA) ^ rol64(u, RotB);
  endfunction

  function automatic logic [63:0] mwc_step();
    logic [127:0] acc;
    int unsigned  nxt;
    nxt = (mwc_idx + 1) % Lag;
    acc = {64'd0, MwcMult} * {64'd0, mwc_words[mwc_idx]};
    acc = acc + {64'd0, mwc_words[nxt]} + {64'd0, mwc_carry};
    mwc_words[mwc_idx] = acc[63:0];
    mwc_carry = acc[127:64];
    mwc_idx = nxt;
    return acc[63:0];
  endfunction

  function automatic void mwc_seed(logic [63:0] s0, logic [63:0] s1);
    logic [63:0] w;
    mwc_idx = 0;
    mwc_carry = CarryStart;
    for (int k = 0; k < Lag; k++) begin
      w = scramble_next(s0);
      w = w + scramble_next(s1);
      mwc_words[k] = w;
    end
    for (int k = 0; k < Lag * Lag; k++) void'(mwc_step());
  endfunction

  initial begin
    for (int k = 0; k < Lag; k++) mwc_words[k] = '0;
    mwc_carry = '0;
    mwc_idx = 0;
  end

  // predict on input accept, check on output accept
  always @(posedge clk_i) begin
    logic [63:0] want;
    logic [63:0] typed_word;
    bit          typed;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $error("unexpected random_word %h", random_word_o);
          errors++;
        end else begin
          want = pending_words.pop_front();
          typed = typed_q.pop_front();
          typed_word = typed_word_q.pop_front();
          checked++;
          if (random_word_o !== want) begin
            $error("random_word expected %h actual %h", want, random_word_o);
            errors++;
          end
          if (typed && random_word_o !== typed_word) begin
            $error("random_word expected %h actual %h", typed_word, random_word_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        accepted++;
        if (op_e'(operation_i) == OP_SEED) begin
          seed_count++;
          mwc_seed(seed_low_i, seed_high_i);
        end else begin
          gen_count++;
          pending_words.push_back(mwc_step());
          typed_q.push_back(cur_typed);
          typed_word_q.push_back(cur_word);
        end
      end
    end
  end

  task automatic send_word(op_e op, logic [63:0] lo, logic [63:0] hi);
    in_valid_i = 1'b1;
    operation_i = op;
    seed_low_i = lo;
    seed_high_i = hi;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic add_row(op_e op, logic [63:0] lo, logic [63:0] hi, bit typed,
                         logic [63:0] word);
    row_t r;
    r.op = op; r.lo = lo; r.hi = hi; r.typed = typed; r.word = word;
    dir_rows.push_back(r);
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk_i);
        if (!hold_done && accepted >= 300) begin
          out_stall_i = 1'b1;
          repeat (400) @(negedge clk_i);
          hold_done = 1;
        end
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(0, 9) < 3);
          default: out_stall_i = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial begin
    int burst;
    int rand_seeds;
    int wait_cycles;
    op_e op;
    // generates straight after reset run on all-zero words
    add_row(OP_GEN, '0, '0, 1, 64'd0);
    add_row(OP_GEN, '1, '1, 1, 64'd0);
    add_row(OP_GEN, 64'h8000_0000_0000_0001, '0, 1, 64'd0);
    add_row(OP_SEED, '0, '0, 0, '0);
    for (int k = 0; k < 4; k++) add_row(OP_GEN, '1, '0, 0, '0);
    add_row(OP_SEED, '1, '1, 0, '0);
    for (int k = 0; k < 4; k++) add_row(OP_GEN, '0, '1, 0, '0);
    add_row(OP_SEED, '1, '0, 0, '0);
    for (int k = 0; k < 3; k++) add_row(OP_GEN, '0, '0, 0, '0);
    add_row(OP_SEED, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0, '0);
    for (int k = 0; k < 3; k++) add_row(OP_GEN, '0, '0, 0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      sender_gap();
      cur_typed = dir_rows[k].typed;
      cur_word = dir_rows[k].word;
      send_word(dir_rows[k].op, dir_rows[k].lo, dir_rows[k].hi);
    end
    cur_typed = 0;
    cur_word = '0;

    rand_seeds = 0;
    burst = 0;
    for (int n = 0; n < RandWords; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        sender_gap();
      end
      burst--;
      op = OP_GEN;
      if (rand_seeds < MaxRandSeeds && $urandom_range(0, 127) == 0) begin
        op = OP_SEED;
        rand_seeds++;
      end
      send_word(op, {$urandom, $urandom}, {$urandom, $urandom});
    end
    in_valid_i = 1'b0;

    wait_cycles = 0;
    while (pending_words.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("random_word expected %0d more words", pending_words.size());
      errors++;
    end
    $display("Covered %0d words: %0d generates, %0d seeds, %0d outputs checked.",
             accepted, gen_count, seed_count, checked);
    $display("Post-reset zero stream, seed extremes, bursty input, long output hold-off.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
